// ===== hw/rtl/xed_pkg.sv =====
// Shared types and constants for the XML entity decoder.
package xed_pkg;

  typedef logic [7:0] byte_t;

  localparam int HOLD_MAX    = 4;  // bytes held after an ampersand
  localparam int MAX_OUT     = 6;  // results one input byte can cause
  localparam int NUM_ENT     = 4;
  localparam int NAME_MAX    = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam byte_t CH_AMP  = 8'h26;  // &
  localparam byte_t CH_QUOT = 8'h22;  // "
  localparam byte_t CH_LT   = 8'h3C;  // <
  localparam byte_t CH_GT   = 8'h3E;  // >
  localparam byte_t CH_SEMI = 8'h3B;  // ;

  // Entity names after the ampersand, zero padded.
  localparam byte_t ENT_NAME [NUM_ENT][NAME_MAX] = '{
    '{8'h61, 8'h6D, 8'h70, CH_SEMI, 8'h00},   // amp;
    '{8'h71, 8'h75, 8'h6F, 8'h74, CH_SEMI},   // quot;
    '{8'h6C, 8'h74, CH_SEMI, 8'h00, 8'h00},   // lt;
    '{8'h67, 8'h74, CH_SEMI, 8'h00, 8'h00}    // gt;
  };
  localparam logic [2:0] ENT_LEN  [NUM_ENT] = '{3'd4, 3'd5, 3'd3, 3'd3};
  localparam byte_t      ENT_CHAR [NUM_ENT] = '{CH_AMP, CH_QUOT, CH_LT, CH_GT};

  // One classified input byte: the group of result bytes it produces.
  typedef struct packed {
    logic [2:0]          cnt;    // number of valid bytes, 1..MAX_OUT
    logic                last;   // final byte of the group closes the stream
    byte_t [MAX_OUT-1:0] bytes;  // bytes[0] goes out first
  } xed_entry_t;

endpackage

// ===== hw/rtl/xed_front.sv =====
// Front end: entity matching state and classification of each input byte.
module xed_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  xed_pkg::byte_t     in_byte,
  input  logic               in_last,
  output logic               push_valid,
  input  logic               push_ready,
  output xed_pkg::xed_entry_t push_data
);

  logic                 amp_r, amp_nxt;
  logic [2:0]           hc_r, hc_nxt;
  xed_pkg::byte_t       held_r [xed_pkg::HOLD_MAX];
  logic                 hold_en;

  logic [2:0]           len;
  logic                 full_hit;
  logic                 prefix_hit;
  xed_pkg::byte_t       full_char;
  logic                 match_k;
  xed_pkg::byte_t       seq_b;
  logic                 accept;
  xed_pkg::xed_entry_t  ent;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign len      = hc_r + 3'd1;

  // Compare held bytes plus the new byte against every entity name.
  always_comb begin
    full_hit   = 1'b0;
    prefix_hit = 1'b0;
    full_char  = xed_pkg::CH_AMP;
    for (int k = 0; k < xed_pkg::NUM_ENT; k++) begin
      match_k = (len <= xed_pkg::ENT_LEN[k]);
      for (int i = 0; i < xed_pkg::NAME_MAX; i++) begin
        if (i < xed_pkg::HOLD_MAX && 3'(i) < hc_r) begin
          seq_b = held_r[2'(i)];
        end else begin
          seq_b = in_byte;
        end
        if (3'(i) < len && seq_b != xed_pkg::ENT_NAME[k][i]) begin
          match_k = 1'b0;
        end
      end
      if (match_k) begin
        if (len == xed_pkg::ENT_LEN[k]) begin
          full_hit  = 1'b1;
          full_char = xed_pkg::ENT_CHAR[k];
        end else begin
          prefix_hit = 1'b1;
        end
      end
    end
  end

  // Build the result group and the next match state.
  always_comb begin
    amp_nxt   = amp_r;
    hc_nxt    = hc_r;
    hold_en   = 1'b0;
    ent.last  = in_last;
    ent.cnt   = 3'd0;
    ent.bytes = '0;
    if (!amp_r) begin
      if (in_byte == xed_pkg::CH_AMP && !in_last) begin
        amp_nxt = 1'b1;
        hc_nxt  = 3'd0;
      end else begin
        ent.cnt      = 3'd1;
        ent.bytes[0] = in_byte;
      end
    end else if (full_hit) begin
      ent.cnt      = 3'd1;
      ent.bytes[0] = full_char;
      amp_nxt      = 1'b0;
      hc_nxt       = 3'd0;
    end else if (prefix_hit && len <= 3'(xed_pkg::HOLD_MAX) && !in_last) begin
      hold_en = 1'b1;
      hc_nxt  = len;
    end else begin
      // Flush the ampersand and held bytes, then the new byte unless it reopens a match.
      ent.bytes[0] = xed_pkg::CH_AMP;
      for (int i = 1; i < xed_pkg::MAX_OUT; i++) begin
        if (3'(i - 1) < hc_r) begin
          ent.bytes[i] = held_r[2'(i - 1)];
        end else begin
          ent.bytes[i] = in_byte;
        end
      end
      if (in_byte == xed_pkg::CH_AMP && !in_last) begin
        ent.cnt = len;
        amp_nxt = 1'b1;
        hc_nxt  = 3'd0;
      end else begin
        ent.cnt = hc_r + 3'd2;
        amp_nxt = 1'b0;
        hc_nxt  = 3'd0;
      end
    end
  end

  assign push_valid = accept && (ent.cnt != 3'd0);
  assign push_data  = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= 1'b0;
      hc_r  <= 3'd0;
    end else if (accept) begin
      amp_r <= amp_nxt;
      hc_r  <= hc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_en) begin
      held_r[hc_r[1:0]] <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/xed_queue.sv =====
// Short register FIFO between the front and back ends.
module xed_queue #(
  parameter int DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  xed_pkg::xed_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output xed_pkg::xed_entry_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xed_pkg::xed_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/xed_back.sv =====
// Back end: serializes each result group onto the output stream.
module xed_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  xed_pkg::xed_entry_t pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output xed_pkg::byte_t      out_byte,
  output logic                out_last
);

  xed_pkg::xed_entry_t cur_r;
  logic [2:0]          idx_r;
  logic                busy_r;
  logic                at_end;
  logic                out_fire;

  assign at_end    = (idx_r == cur_r.cnt - 3'd1);
  assign out_fire  = busy_r && out_ready;
  // Load the next group when idle or when the current one finishes.
  assign pop_ready = !busy_r || (out_fire && at_end);

  assign out_valid = busy_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = cur_r.last && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (pop_valid && pop_ready) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (out_fire) begin
      if (at_end) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_data;
    end
  end

endmodule

// ===== hw/rtl/xml_entity_decoder.sv =====
// Top level of the XML entity decoder: front end, group queue, back end.
//
// Usage: feed escaped text one byte per transaction on the in_ stream, with
// in_tlast on the final byte of the stream. Decoded bytes leave on the out_
// stream; &amp; &quot; &lt; &gt; collapse to & " < >, anything else passes
// through unchanged. out_tlast marks the final decoded byte of the stream.
// A partial entity still open at the end of the stream is flushed as
// literal bytes.
//
// Each group is written into the group queue, then into the serializer's
// register, before it shows on out_. Throughput: one input byte per cycle
// while each byte yields at most one output byte and out_tready stays high.
// Bytes inside a candidate entity yield no output. A broken match yields up
// to six bytes, sent one per transaction; the group queue absorbs this while
// it has room, after which in_tready drops.
//
// Reset (rst_n low, synchronous) empties the queue, drops any open match
// and clears out_tvalid. When the receiver stalls, out_tdata/out_tlast hold
// and the queue fills; in_tready falls once QUEUE_DEPTH groups are waiting.
module xml_entity_decoder #(
  parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_last
);

  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;
  xed_pkg::xed_entry_t push_data, pop_data;

  // Classify each byte into a group of zero to six result bytes.
  xed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple the classifier from the output serializer.
  xed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Emit each group one byte per transaction.
  xed_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking stream testbench for the XML entity decoder, with its own decode model.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 400;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 16;  // leave room for stragglers

  // One decoded byte as it leaves the out_ stream.
  typedef struct packed {
    xed_pkg::byte_t data;
    logic           last;
  } text_beat_t;

  // One input transaction. Typed rows carry their single expected byte (or none)
  // inline; every other row is checked against the decode model.
  typedef struct packed {
    xed_pkg::byte_t data;
    logic           last;
    logic           typed;
    logic           exp_some;
    xed_pkg::byte_t exp_byte;
    logic [1:0]     phase;     // selects the idle mix on both sides
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  stim_row_t      stim_rows[$];
  xed_pkg::byte_t frame_q[$];          // bytes of the stream under construction
  text_beat_t     step_q[$];           // decoded bytes of the transaction just accepted
  text_beat_t     expected_beats[$];   // decoded bytes still owed by the block
  string          ent_names[4];
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             error_count   = 0;
  int             random_items  = 0;

  // Mirror of the decoder's match state.
  logic           amp_open = 1'b0;
  int             held_n   = 0;
  xed_pkg::byte_t held[4];

  xml_entity_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // Map an entity index to the character it stands for.
  function automatic xed_pkg::byte_t ent_glyph(input int k);
    case (k)
      0: return xed_pkg::CH_AMP;
      1: return xed_pkg::CH_QUOT;
      2: return xed_pkg::CH_LT;
      default: return xed_pkg::CH_GT;
    endcase
  endfunction

  function automatic void emit_byte(input xed_pkg::byte_t b);
    text_beat_t beat;
    beat.data = b;
    beat.last = 1'b0;
    step_q.push_back(beat);
  endfunction

  // Give up on the open match: the ampersand and the held bytes go out as text.
  function automatic void flush_held();
    emit_byte(xed_pkg::CH_AMP);
    for (int i = 0; i < held_n; i++) emit_byte(held[i]);
    amp_open = 1'b0;
    held_n   = 0;
  endfunction

  // Advance the model by one accepted byte; leave its decoded bytes in step_q.
  function automatic void decode_byte(input xed_pkg::byte_t b, input logic is_last);
    xed_pkg::byte_t seq[5];
    int             len;
    int             full;
    logic           prefix;
    logic           same;
    text_beat_t     tail;
    step_q.delete();
    if (!amp_open) begin
      if (b == xed_pkg::CH_AMP) begin
        amp_open = 1'b1;
        held_n   = 0;
      end else begin
        emit_byte(b);
      end
    end else begin
      for (int i = 0; i < held_n; i++) seq[i] = held[i];
      seq[held_n] = b;
      len    = held_n + 1;
      full   = -1;
      prefix = 1'b0;
      // Compare the candidate against every entity name of sufficient length.
      for (int k = 0; k < 4; k++) begin
        if (len <= ent_names[k].len()) begin
          same = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (seq[i] != xed_pkg::byte_t'(ent_names[k][i])) same = 1'b0;
          end
          if (same) begin
            if (len == ent_names[k].len()) full = k;
            else prefix = 1'b1;
          end
        end
      end
      if (full >= 0) begin
        emit_byte(ent_glyph(full));
        amp_open = 1'b0;
        held_n   = 0;
      end else if (prefix && len <= xed_pkg::HOLD_MAX) begin
        held[held_n] = b;
        held_n       = len;
      end else begin
        // Broken match: flush, then a new ampersand reopens instead of printing.
        flush_held();
        if (b == xed_pkg::CH_AMP) begin
          amp_open = 1'b1;
          held_n   = 0;
        end else begin
          emit_byte(b);
        end
      end
    end
    if (is_last) begin
      // End of stream: flush any partial entity and mark the final byte.
      if (amp_open) flush_held();
      if (step_q.size() > 0) begin
        tail      = step_q.pop_back();
        tail.last = 1'b1;
        step_q.push_back(tail);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  function automatic void add_row(input xed_pkg::byte_t d, input logic is_last,
                                  input logic typed, input logic some,
                                  input xed_pkg::byte_t e, input logic [1:0] ph);
    stim_row_t r;
    r.data     = d;
    r.last     = is_last;
    r.typed    = typed;
    r.exp_some = some;
    r.exp_byte = e;
    r.phase    = ph;
    stim_rows.push_back(r);
  endfunction

  // Append the first n characters of an entity name to the open stream.
  function automatic void append_name(input int k, input int n);
    for (int i = 0; i < n; i++) frame_q.push_back(xed_pkg::byte_t'(ent_names[k][i]));
  endfunction

  function automatic void append_str(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(xed_pkg::byte_t'(s[i]));
  endfunction

  // Move the open stream into the stimulus, marking its final byte if it closes.
  function automatic void flush_frame(input logic close, input logic [1:0] ph);
    for (int i = 0; i < frame_q.size(); i++) begin
      add_row(frame_q[i], close && (i == frame_q.size() - 1), 1'b0, 1'b0, 8'h00, ph);
    end
    frame_q.delete();
  endfunction

  // A whole entity whose outcome is plain to see: silence, then the glyph.
  function automatic void add_entity_typed(input int k, input logic close);
    int n;
    n = ent_names[k].len();
    add_row(xed_pkg::CH_AMP, 1'b0, 1'b1, 1'b0, 8'h00, 2'd0);
    for (int i = 0; i < n - 1; i++) begin
      add_row(xed_pkg::byte_t'(ent_names[k][i]), 1'b0, 1'b1, 1'b0, 8'h00, 2'd0);
    end
    add_row(xed_pkg::byte_t'(ent_names[k][n - 1]), close, 1'b1, 1'b1, ent_glyph(k), 2'd0);
  endfunction

  // Random streams: whole entities (the likeliest piece) inside random text, plus
  // broken and unknown entities and matches still open at the end of the stream.
  task automatic build_random();
    int         pieces;
    int         sel;
    int         k;
    int         p;
    logic [1:0] ph;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) ph = 2'd0;
      else if (random_items < 2 * RANDOM_ITEMS / 3) ph = 2'd1;
      else ph = 2'd2;
      pieces = $urandom_range(1, 10);
      repeat (pieces) begin
        sel = $urandom_range(0, 9);
        k   = $urandom_range(0, 3);
        case (sel)
          0, 1, 2: begin
            frame_q.push_back(xed_pkg::byte_t'($urandom_range(0, 255)));
          end
          3, 4, 5, 6: begin
            frame_q.push_back(xed_pkg::CH_AMP);
            append_name(k, ent_names[k].len());
          end
          7: begin
            // Proper prefix broken by an arbitrary byte.
            p = $urandom_range(1, ent_names[k].len() - 1);
            frame_q.push_back(xed_pkg::CH_AMP);
            append_name(k, p);
            frame_q.push_back(xed_pkg::byte_t'($urandom_range(0, 255)));
          end
          8: begin
            frame_q.push_back(xed_pkg::CH_AMP);
            if ($urandom_range(0, 1) == 0) append_str("apos;");
            else append_str("#38;");
          end
          default: begin
            // Leave the match open for the next piece or the end of stream.
            p = $urandom_range(0, ent_names[k].len() - 1);
            frame_q.push_back(xed_pkg::CH_AMP);
            append_name(k, p);
          end
        endcase
      end
      random_items += frame_q.size();
      flush_frame(1'b1, ph);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endfunction

  // Compare one output transaction with the oldest decoded byte owed.
  function automatic void check_beat(input xed_pkg::byte_t data, input logic is_last);
    text_beat_t want;
    if (expected_beats.size() == 0) begin
      note_error($sformatf("unexpected output byte %02h last %0b", data, is_last));
    end else begin
      want = expected_beats.pop_front();
      if (data !== want.data) begin
        note_error($sformatf("out_byte expected %02h got %02h", want.data, data));
      end
      if (is_last !== want.last) begin
        note_error($sformatf("out_last expected %0b got %0b (byte %02h)",
                             want.last, is_last, want.data));
      end
    end
  endfunction

  // Receiver: sample the handshake at the edge, then pick the next ready level.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_beat(out_tdata, out_tlast);
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Present one byte, hold it until the block takes it, then predict its output.
  task automatic send_row(input stim_row_t r);
    text_beat_t beat;
    case (r.phase)
      2'd0: begin
        send_idle_pct = 12;
        recv_idle_pct = 51;
      end
      2'd1: begin
        send_idle_pct = 51;
        recv_idle_pct = 12;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r.data;
    in_tlast  <= r.last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    // Transaction accepted at this edge; the result cannot appear before the next.
    decode_byte(r.data, r.last);
    if (r.typed) begin
      if (r.exp_some) begin
        beat.data = r.exp_byte;
        beat.last = r.last;
        expected_beats.push_back(beat);
      end
    end else begin
      foreach (step_q[i]) expected_beats.push_back(step_q[i]);
    end
  endtask

  initial begin
    ent_names[0] = "amp;";
    ent_names[1] = "quot;";
    ent_names[2] = "lt;";
    ent_names[3] = "gt;";

    // Directed rows: byte extremes, the amp, quot and lt entities, a held name broken
    // after four bytes, an ampersand breaking a match, and a stream ending mid-match.
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 2'd0);
    add_row(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 2'd0);
    add_entity_typed(0, 1'b0);
    add_entity_typed(1, 1'b0);
    add_entity_typed(2, 1'b1);
    append_str("&quotx");
    flush_frame(1'b0, 2'd0);
    append_str("&&g");
    flush_frame(1'b1, 2'd0);

    build_random();

    // Hold reset low from the start, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_row(stim_rows[i]);
    in_tvalid <= 1'b0;

    // Drain: wait for every owed byte, then watch for extras.
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (expected_beats.size() != 0) begin
      note_error($sformatf("missing output byte %02h", expected_beats.pop_front().data));
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
